[sv/ms_pkg.sv]
`default_nettype none
package ms_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int DATA_W  = 32;
  localparam int REQ_W   = 2;
  localparam int TOTAL_W = 5;
  localparam int STAT_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_POPMAX = 2'd2,
    REQ_QUERY  = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle control for the shared compare unit
  typedef struct packed {
    logic             vld;
    logic             first;
    logic [IDX_W-1:0] idx;
  } scan_ctrl_t;

  // Running result of the compare unit
  typedef struct packed {
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] max;
    logic [IDX_W-1:0]         max_idx;
  } scan_res_t;

endpackage
`default_nettype wire

[sv/ms_req_if.sv]
`default_nettype none
interface ms_req_if;
  import ms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface
`default_nettype wire

[sv/ms_rsp_if.sv]
`default_nettype none
interface ms_rsp_if;
  import ms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] removed_value;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] max_value;
  logic [TOTAL_W-1:0]       entry_total;
  logic                     is_empty;
  logic [STAT_W-1:0]        status;

  modport source (output valid, removed_value, top_value, max_value, entry_total,
                  is_empty, status, input ready);
  modport sink   (input valid, removed_value, top_value, max_value, entry_total,
                  is_empty, status, output ready);
endinterface
`default_nettype wire

[sv/ms_ram.sv]
`default_nettype none
module ms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[sv/ms_max_unit.sv]
`default_nettype none
module ms_max_unit (
  input  wire logic                             clk,
  input  wire ms_pkg::scan_ctrl_t               ctrl,
  input  wire logic signed [ms_pkg::DATA_W-1:0] rd_data,
  output      ms_pkg::scan_res_t                res
);
  import ms_pkg::*;

  scan_res_t res_r;

  // Entries arrive top first; strict compare keeps the topmost copy.
  always_ff @(posedge clk) begin
    if (ctrl.vld) begin
      if (ctrl.first) begin
        res_r.top     <= rd_data;
        res_r.max     <= rd_data;
        res_r.max_idx <= ctrl.idx;
      end else if (rd_data > res_r.max) begin
        res_r.max     <= rd_data;
        res_r.max_idx <= ctrl.idx;
      end
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

[sv/max_stack_core.sv]
`default_nettype none
// Bounded stack of signed 32-bit values (ms_pkg::STACK_DEPTH entries) that
// tracks its largest entry. One request per transfer on in_req: push, pop
// top, pop maximum (removes the topmost copy of the largest value, entries
// above slide down) or query. Each request gives exactly one result transfer
// on out_rsp with the removed value, top, maximum, count, empty flag and
// status (removal from empty or push onto full leaves the stack untouched).
// Requests are handled one at a time; in_req.ready is high only while idle.
// Entries live in a single-port-write / single-port-read RAM with registered
// read, and top/maximum are found by one compare unit that walks the stack
// one entry per cycle. Query, full and empty cases go straight to the
// result; push or pop then rescans the remaining entries from the top
// (a pop that empties the stack skips the scan); pop maximum first reads
// each entry above the removed one and writes it one place lower, then
// rescans. The single RAM read port sets the pace of these walks.
module max_stack_core (
  input wire logic clk,
  input wire logic rst_n,
  ms_req_if.sink   in_req,
  ms_rsp_if.source out_rsp
);
  import ms_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SCAN,
    S_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]         ptr_r, ptr_nxt;     // read address being issued
  logic                     more_r, more_nxt;   // reads still to issue
  logic                     rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic signed [DATA_W-1:0] removed_r, removed_nxt;
  status_t                  status_r, status_nxt;

  // RAM port signals
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] rd_data;

  scan_ctrl_t               scan_ctrl;
  scan_res_t                scan_res;

  // Count arithmetic
  logic [CNT_W-1:0]         cnt_m1, cnt_m2;
  logic [IDX_W-1:0]         top_idx;           // index of current top entry
  logic [IDX_W-1:0]         below_idx;         // index just under the top
  logic                     is_full, is_zero;
  logic                     in_xfer, out_xfer;
  req_type_t                req;
  logic [31:0]              cnt_ext;

  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign cnt_m2    = cnt_r - CNT_W'(2);
  assign top_idx   = cnt_m1[IDX_W-1:0];
  assign below_idx = cnt_m2[IDX_W-1:0];
  assign is_full   = (cnt_r == CNT_W'(STACK_DEPTH));
  assign is_zero   = (cnt_r == '0);
  assign in_xfer   = in_req.valid && in_req.ready;
  assign out_xfer  = out_rsp.valid && out_rsp.ready;
  assign req       = req_type_t'(in_req.req_type);

  ms_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  // Compare unit sees every entry read during a scan, top entry first
  always_comb begin
    scan_ctrl.vld   = (state_r == S_SCAN) && rd_vld_r;
    scan_ctrl.first = (rd_idx_r == top_idx);
    scan_ctrl.idx   = rd_idx_r;
  end

  ms_max_unit u_max (
    .clk     (clk),
    .ctrl    (scan_ctrl),
    .rd_data (rd_data),
    .res     (scan_res)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    more_nxt    = more_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    wr_en       = 1'b0;
    wr_addr     = cnt_r[IDX_W-1:0];
    wr_data     = in_req.push_value;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          removed_nxt = '0;
          status_nxt  = ST_OK;
          state_nxt   = S_OUT;
          unique case (req)
            REQ_PUSH: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                // new entry lands at the old count; rescan from there
                wr_en     = 1'b1;
                cnt_nxt   = cnt_r + CNT_W'(1);
                ptr_nxt   = cnt_r[IDX_W-1:0];
                more_nxt  = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            REQ_POP, REQ_POPMAX: begin
              if (is_zero) begin
                status_nxt = ST_EMPTY;
              end else if (req == REQ_POP || scan_res.max_idx == top_idx) begin
                // removing the top: no shift needed
                removed_nxt = (req == REQ_POP) ? scan_res.top : scan_res.max;
                cnt_nxt     = cnt_m1;
                if (cnt_m1 != '0) begin
                  ptr_nxt   = below_idx;
                  more_nxt  = 1'b1;
                  state_nxt = S_SCAN;
                end
              end else begin
                // slide entries above the maximum down by one
                removed_nxt = scan_res.max;
                ptr_nxt     = scan_res.max_idx + IDX_W'(1);
                more_nxt    = 1'b1;
                state_nxt   = S_SHIFT;
              end
            end
            default: begin
              // query: results come from the cached scan
            end
          endcase
        end
      end

      S_SHIFT: begin
        if (more_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r;
          if (ptr_r == top_idx) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + IDX_W'(1);
          end
        end
        if (rd_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_r - IDX_W'(1);
          wr_data = rd_data;
          if (rd_idx_r == top_idx) begin
            cnt_nxt    = cnt_m1;
            ptr_nxt    = below_idx;
            more_nxt   = 1'b1;
            rd_vld_nxt = 1'b0;
            state_nxt  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (more_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r;
          if (ptr_r == '0) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r - IDX_W'(1);
          end
        end
        if (rd_vld_r && rd_idx_r == '0) begin
          rd_vld_nxt = 1'b0;
          more_nxt   = 1'b0;
          state_nxt  = S_OUT;
        end
      end

      S_OUT: begin
        if (out_xfer) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      more_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      more_r   <= more_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
    ptr_r     <= ptr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

  // Result transfer: registers only, held through any stall
  assign cnt_ext               = 32'(cnt_r);
  assign in_req.ready          = (state_r == S_IDLE);
  assign out_rsp.valid         = (state_r == S_OUT);
  assign out_rsp.removed_value = removed_r;
  assign out_rsp.top_value     = is_zero ? '0 : scan_res.top;
  assign out_rsp.max_value     = is_zero ? '0 : scan_res.max;
  assign out_rsp.entry_total   = cnt_ext[TOTAL_W-1:0];
  assign out_rsp.is_empty      = is_zero;
  assign out_rsp.status        = status_r;

endmodule
`default_nettype wire
